@@ sv/ffba_pkg.sv @@
`default_nettype none
package ffba_pkg;

  localparam int MAX_BLOCKS   = 32;
  localparam int HEADER_BYTES = 20;
  localparam int ALIGN_BYTES  = 4;   // power of two
  localparam int WORD_BYTES   = 4;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [31:0] HDR       = 32'(HEADER_BYTES);
  localparam logic [31:0] ALIGN_M   = 32'(ALIGN_BYTES - 1);
  localparam logic [31:0] HDR_ALIGN = 32'(((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                          * ALIGN_BYTES);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_END  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [23:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [2:0]  status;
    logic [31:0] free_bytes;
    logic [31:0] total_bytes;
  } res_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] cap;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
    logic             ins;
    logic [IDX_W-1:0] ins_idx;
    entry_t           ins_entry;
    logic             rem;
    logic [IDX_W-1:0] rem_idx;
  } tbl_ctl_t;

endpackage
`default_nettype wire

@@ sv/ffba_table.sv @@
`default_nettype none
module ffba_table (
  input  wire logic              clk,
  input  wire ffba_pkg::tbl_ctl_t ctl,
  input  wire logic [ffba_pkg::IDX_W-1:0] rd_idx,
  output ffba_pkg::entry_t       rd_entry
);
  import ffba_pkg::*;

  entry_t ent [MAX_BLOCKS];

  assign rd_entry = ent[rd_idx];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_ent
    entry_t nxt;
    always_comb begin
      nxt = ent[k];
      if (k < MAX_BLOCKS - 1) begin
        if (ctl.rem && IDX_W'(k) >= ctl.rem_idx) begin
          nxt = ent[(k < MAX_BLOCKS - 1) ? k + 1 : k];
        end
      end
      if (ctl.ins && IDX_W'(k) == ctl.ins_idx) begin
        nxt = ctl.ins_entry;
      end else if (k > 0) begin
        if (ctl.ins && IDX_W'(k) > ctl.ins_idx) begin
          nxt = ent[(k > 0) ? k - 1 : k];
        end
      end
      if (ctl.wr && IDX_W'(k) == ctl.wr_idx) begin
        nxt = ctl.wr_entry;
      end
    end
    always_ff @(posedge clk) begin
      ent[k] <= nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/first_fit_block_allocator_core.sv @@
`default_nettype none
// First-fit heap allocator. A request is taken when start is high and busy low;
// one result word follows, shown for one cycle with done, and must be taken then.
// The block table is walked one entry per cycle by a single compare unit; table shifts
// for split and merge are applied together with the entry write that goes with them.
// Configuration writes are taken only while idle; writing heap_base empties the table.
module first_fit_block_allocator_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire ffba_pkg::req_t request,
  output logic                done,
  output ffba_pkg::res_t      result,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_index,
  input  wire logic [31:0]    cfg_data
);
  import ffba_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ASCAN  = 3'd1;
  localparam logic [2:0] S_RSCAN  = 3'd2;
  localparam logic [2:0] S_RNEXT  = 3'd3;
  localparam logic [2:0] S_RPREV  = 3'd4;
  localparam logic [2:0] S_RTRIM  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [31:0]      heap_base;
  logic [31:0]      heap_end;
  logic [31:0]      heap_top;
  req_t             req;
  logic [31:0]      length;
  logic [31:0]      mcap;
  logic [31:0]      mstart;
  logic [31:0]      data_r;
  logic [2:0]       status_r;

  tbl_ctl_t   ctl;
  entry_t     rd;

  logic at_end, fit, split, hit, last;

  ffba_table u_table (
    .clk      (clk),
    .ctl      (ctl),
    .rd_idx   (ptr[IDX_W-1:0]),
    .rd_entry (rd)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;

  assign at_end = (ptr >= count);
  assign fit    = rd.free && (rd.cap >= {8'd0, req.request_size});
  assign split  = ({1'b0, length} + 33'(WORD_BYTES) < {1'b0, rd.cap}) &&
                  (count < CNT_W'(MAX_BLOCKS));
  assign hit    = ({1'b0, rd.start} + {1'b0, HDR}) == {1'b0, req.block_address};
  assign last   = (ptr + CNT_W'(1)) == count;

  always_comb begin
    ctl = '0;
    unique case (state)
      S_ASCAN: begin
        if (!at_end && fit) begin
          ctl.wr       = 1'b1;
          ctl.wr_idx   = ptr[IDX_W-1:0];
          ctl.wr_entry = '{start: rd.start, cap: split ? length - HDR : rd.cap, free: 1'b0};
          ctl.ins      = split;
          ctl.ins_idx  = IDX_W'(ptr + CNT_W'(1));
          ctl.ins_entry = '{start: rd.start + length, cap: rd.cap - length, free: 1'b1};
        end else if (at_end && count < CNT_W'(MAX_BLOCKS) &&
                     ({1'b0, heap_top} + {1'b0, length} <= {1'b0, heap_end})) begin
          ctl.wr       = 1'b1;
          ctl.wr_idx   = count[IDX_W-1:0];
          ctl.wr_entry = '{start: heap_top, cap: length - HDR, free: 1'b0};
        end
      end
      S_RSCAN: begin
        if (!at_end && hit) begin
          ctl.wr       = 1'b1;
          ctl.wr_idx   = ptr[IDX_W-1:0];
          ctl.wr_entry = '{start: rd.start, cap: rd.cap, free: 1'b1};
        end
      end
      S_RNEXT: begin
        if (!at_end && rd.free) begin
          ctl.wr       = 1'b1;
          ctl.wr_idx   = IDX_W'(ptr - CNT_W'(1));
          ctl.wr_entry = '{start: mstart, cap: mcap + rd.cap + HDR, free: 1'b1};
          ctl.rem      = 1'b1;
          ctl.rem_idx  = ptr[IDX_W-1:0];
        end
      end
      S_RPREV: begin
        if (rd.free) begin
          ctl.wr       = 1'b1;
          ctl.wr_idx   = ptr[IDX_W-1:0];
          ctl.wr_entry = '{start: rd.start, cap: rd.cap + mcap + HDR, free: 1'b1};
          ctl.rem      = 1'b1;
          ctl.rem_idx  = IDX_W'(ptr + CNT_W'(1));
        end
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      heap_base <= '0;
      heap_end  <= '0;
      heap_top  <= HDR_ALIGN;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_HEAP_BASE) begin
              heap_base <= cfg_data;
              count     <= '0;
              heap_top  <= cfg_data + HDR_ALIGN;
            end else begin
              heap_end <= cfg_data;
            end
          end
          if (start) begin
            req      <= request;
            length   <= ({8'd0, request.request_size} + HDR + ALIGN_M) & ~ALIGN_M;
            ptr      <= '0;
            data_r   <= '0;
            status_r <= ST_OK;
            if (request.mode == MODE_ALLOC) begin
              if (request.request_size == '0) begin
                status_r <= ST_ZERO;
                state    <= S_DONE;
              end else begin
                state <= S_ASCAN;
              end
            end else if (request.block_address == '0 || request.block_address < heap_base) begin
              status_r <= ST_UNKNOWN;
              state    <= S_DONE;
            end else begin
              state <= S_RSCAN;
            end
          end
        end
        S_ASCAN: begin
          if (!at_end) begin
            if (fit) begin
              data_r <= rd.start + HDR;
              if (split) begin
                count <= count + CNT_W'(1);
              end
              state <= S_DONE;
            end else begin
              ptr <= ptr + CNT_W'(1);
            end
          end else begin
            if (count >= CNT_W'(MAX_BLOCKS)) begin
              status_r <= ST_FULL;
            end else if ({1'b0, heap_top} + {1'b0, length} > {1'b0, heap_end}) begin
              status_r <= ST_NOSPACE;
            end else begin
              count    <= count + CNT_W'(1);
              heap_top <= heap_top + length;
              data_r   <= heap_top + HDR;
            end
            state <= S_DONE;
          end
        end
        S_RSCAN: begin
          if (at_end) begin
            status_r <= ST_UNKNOWN;
            state    <= S_DONE;
          end else if (hit) begin
            mcap   <= rd.cap;
            mstart <= rd.start;
            ptr    <= ptr + CNT_W'(1);
            state  <= S_RNEXT;
          end else begin
            ptr <= ptr + CNT_W'(1);
          end
        end
        S_RNEXT: begin
          if (!at_end && rd.free) begin
            mcap  <= mcap + rd.cap + HDR;
            count <= count - CNT_W'(1);
          end
          if (ptr >= CNT_W'(2)) begin
            ptr   <= ptr - CNT_W'(2);
            state <= S_RPREV;
          end else begin
            ptr   <= ptr - CNT_W'(1);
            state <= S_RTRIM;
          end
        end
        S_RPREV: begin
          if (rd.free) begin
            mcap   <= rd.cap + mcap + HDR;
            mstart <= rd.start;
            count  <= count - CNT_W'(1);
          end else begin
            ptr <= ptr + CNT_W'(1);
          end
          state <= S_RTRIM;
        end
        S_RTRIM: begin
          if (last) begin
            heap_top <= mstart;
            count    <= count - CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          result.data_address <= data_r;
          result.status       <= status_r;
          result.free_bytes   <= (heap_end >= heap_top) ? heap_end - heap_top : '0;
          result.total_bytes  <= (heap_end >= heap_base) ? heap_end - heap_base : '0;
          done                <= 1'b1;
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS)) else $error("block count above table size");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("word shown while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request did not start");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DONE) else $error("word without finish step");

endmodule
`default_nettype wire
